FILE: sv/wms_pkg.sv
// Package for the window median select unit: the shared state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wms_pkg;
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_DONE
  } sel_state_t;
endpackage
`default_nettype wire

FILE: sv/wms_select.sv
// Back end: holds one stored window and finds the element of rank count/2.
// Depends on wms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wms_select #(
  parameter int unsigned MAX_ITEMS = 512,
  parameter int unsigned AW = 9,
  parameter int unsigned CW = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic signed [31:0]  wr_data,
  input  wire logic                job_valid,
  output logic                     job_ready,
  input  wire logic [CW-1:0]       job_count,
  input  wire logic                job_ovf,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic signed [31:0]       res_median,
  output logic                     res_ovf
);
  import wms_pkg::*;

  // Rank selection: for each candidate i, count elements j that sort before it
  // (v_j < v_i, or equal with j < i). Candidate whose rank is count/2 wins.
  logic signed [31:0] mem_a [MAX_ITEMS];
  logic signed [31:0] mem_b [MAX_ITEMS];
  logic signed [31:0] rd_a_r, rd_b_r;
  sel_state_t state_r, state_nxt;
  logic [CW-1:0] n_r, i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic [CW-1:0] ip_r, jp_r;
  logic          cmp_v_r, cmp_v_nxt, ovf_r;
  logic signed [31:0] med_r;
  logic [CW-1:0] target;
  logic          ahead;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[i_r[AW-1:0]];
    rd_b_r <= mem_b[j_r[AW-1:0]];
  end

  assign target = n_r >> 1;
  assign ahead = (rd_b_r < rd_a_r) || ((rd_b_r == rd_a_r) && (jp_r < ip_r));
  assign job_ready = (state_r == SEL_IDLE);
  assign res_valid = (state_r == SEL_DONE);
  assign res_median = med_r;
  assign res_ovf = ovf_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    rank_nxt = rank_r;
    cmp_v_nxt = 1'b0;
    unique case (state_r)
      SEL_IDLE: begin
        if (job_valid) begin
          state_nxt = SEL_SCAN;
          i_nxt = '0;
          j_nxt = '0;
          rank_nxt = '0;
        end
      end
      SEL_SCAN: begin
        if (j_r < n_r) begin
          j_nxt = j_r + 1'b1;
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r && ahead) rank_nxt = rank_r + 1'b1;
        if (j_r == n_r && !cmp_v_r) begin
          if (rank_r == target) begin
            state_nxt = SEL_DONE;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = '0;
            rank_nxt = '0;
          end
        end
      end
      SEL_DONE: begin
        if (res_ready) state_nxt = SEL_IDLE;
      end
      default: state_nxt = SEL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
    rank_r <= rank_nxt;
    ip_r <= i_r;
    jp_r <= j_r;
    if (state_r == SEL_IDLE && job_valid) begin
      n_r <= job_count;
      ovf_r <= job_ovf;
    end
    if (state_r == SEL_SCAN && j_r == n_r && !cmp_v_r) med_r <= rd_a_r;
  end

  a_done_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEL_SCAN && state_nxt == SEL_DONE) |-> (rank_r == target))
    else $error("result taken at wrong rank");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_ready |-> !res_valid) else $error("ready while result pending");
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(med_r)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: sv/wms_front.sv
// Front end: accepts beats, writes the store, counts, flags drops and queues
// one finished window for the back end. Depends on wms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wms_front #(
  parameter int unsigned MAX_ITEMS = 512,
  parameter int unsigned AW = 9,
  parameter int unsigned CW = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_value,
  input  wire logic                in_last,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [31:0]       wr_data,
  output logic                     job_valid,
  input  wire logic                job_ready,
  output logic [CW-1:0]            job_count,
  output logic                     job_ovf
);
  import wms_pkg::*;

  // One-entry job queue: the store is shared, so the front waits while a
  // window is queued or under selection.
  logic [CW-1:0] cnt_r, cnt_nxt, qcnt_r;
  logic          drop_r, drop_nxt, qv_r, busy_r;
  logic          acc, full;

  assign in_ready = !qv_r && !busy_r;
  assign acc = in_valid && in_ready;
  assign full = (cnt_r == CW'(MAX_ITEMS));
  assign wr_en = acc && !full;
  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = in_value;
  assign job_valid = qv_r;
  assign job_count = qcnt_r;
  assign job_ovf = drop_r;

  // The drop flag travels with the queued window and clears once the back
  // end has taken it; no beat is accepted while a window is queued.
  always_comb begin
    cnt_nxt = cnt_r;
    drop_nxt = drop_r;
    if (acc) begin
      if (full) drop_nxt = 1'b1;
      else cnt_nxt = cnt_r + 1'b1;
    end
    if (qv_r && job_ready) drop_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      drop_r <= 1'b0;
      qv_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      drop_r <= drop_nxt;
      if (acc && in_last) begin
        qv_r <= 1'b1;
        qcnt_r <= cnt_nxt;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
      if (qv_r && job_ready) begin
        qv_r <= 1'b0;
        busy_r <= 1'b1;
      end else if (busy_r && job_ready) begin
        busy_r <= 1'b0;
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS)) else $error("count past depth");
  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full) else $error("write into full store");
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job_count != '0)) else $error("empty window queued");
endmodule
`default_nettype wire

FILE: sv/window_median_select_unit.sv
// Top level of the window median select unit: front end, back end and store.
// Depends on wms_pkg, wms_front and wms_select.
//
// Usage: stream a window of signed 32-bit values on the in_ channel, one beat
// per cycle, marking the final beat with in_tlast. That beat produces one
// result beat on out_: the element of zero-based rank count/2 of the window
// in ascending order (upper median for even counts) and an overflow flag that
// is set if beats beyond MAX_ITEMS were dropped from this window. Beats
// without tlast produce nothing.
// Loading runs at one beat per cycle. After the last beat the back end ranks
// candidates in storage order: each candidate is compared with every stored
// element through the two read ports of the store, one compare per cycle,
// and ranking stops at the first candidate of rank count/2. in_tready is low
// after the last beat until the result beat has been taken and the back end
// is idle again. If the receiver stalls, the result holds on out_ and the
// input stays closed. Reset clears counts, flags and control state; the
// store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module window_median_select_unit #(
  parameter int unsigned MAX_ITEMS = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,   // last_item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] median
  output logic             out_tuser   // [0] overflow
);
  import wms_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic                wr_en, job_valid, job_ready, job_ovf, res_ovf;
  logic [AW-1:0]       wr_addr;
  logic signed [31:0]  wr_data, res_median;
  logic [CW-1:0]       job_count;

  wms_front #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_value($signed(in_tdata)), .in_last(in_tlast),
    .wr_en, .wr_addr, .wr_data,
    .job_valid, .job_ready, .job_count, .job_ovf
  );

  wms_select #(.MAX_ITEMS(MAX_ITEMS), .AW(AW), .CW(CW)) u_sel (
    .clk, .rst_n,
    .wr_en, .wr_addr, .wr_data,
    .job_valid, .job_ready, .job_count, .job_ovf,
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_median, .res_ovf
  );

  assign out_tdata = res_median;
  assign out_tuser = res_ovf;
endmodule
`default_nettype wire
